### src/bsa_pkg.sv
// shared types and constants for the bitmap slot allocator
package bsa_pkg;

	localparam int SLOTS    = 64;
	localparam int SLOT_W   = 6;
	localparam int CNT_W    = 7;
	localparam int ADDR_W   = 64;
	localparam int STRIDE_W = 13;
	localparam int OFS_W    = SLOT_W + STRIDE_W;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 2 + SLOT_W + 2 * ADDR_W;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_XLATE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		CFG_SLOT_COUNT = 2'd0,
		CFG_CPU_BASE   = 2'd1,
		CFG_GPU_BASE   = 2'd2,
		CFG_STRIDE     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} bsa_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} bsa_cmd_t;

	typedef struct packed {
		logic out_free;
	} bsa_sts_t;

endpackage

### src/bsa_ctrl.sv
// controller state machine: accept, search/update, result load
module bsa_ctrl
	import bsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bsa_sts_t sts,
	output bsa_cmd_t cmd
);

	bsa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/bsa_datapath.sv
// datapath: config registers, used bitmap, first-free search, address math, output register
module bsa_datapath
	import bsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [ADDR_W-1:0]  cfg_data,
	input  logic [IN_W-1:0]    in_data,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [OUT_W-1:0]   out_data,
	input  bsa_cmd_t           cmd,
	output bsa_sts_t           sts
);

	logic [CNT_W-1:0]    slot_count_q;
	logic [ADDR_W-1:0]   cpu_base_q;
	logic [ADDR_W-1:0]   gpu_base_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [SLOTS-1:0]    used_q;

	op_t               op_q;
	logic [SLOT_W-1:0] idx_q;

	stat_t             stat_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              addr_en_s1;
	logic [OFS_W-1:0]  ofs_s1;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [CNT_W-1:0]  active;
	logic [SLOTS-1:0]  free_vec;
	logic [SLOTS-1:0]  low_bit;
	logic [SLOT_W-1:0] first_free;
	logic              found;
	logic              idx_bad;
	stat_t             stat_d;
	logic [SLOT_W-1:0] slot_d;
	logic              addr_en_d;
	logic              set_en;
	logic              clr_en;
	logic [ADDR_W-1:0] cpu_addr;
	logic [ADDR_W-1:0] gpu_addr;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CNT_W'(SLOTS);
			cpu_base_q   <= '0;
			gpu_base_q   <= '0;
			stride_q     <= STRIDE_W'(32);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SLOT_COUNT: slot_count_q <= cfg_data[CNT_W-1:0];
				CFG_CPU_BASE:   cpu_base_q   <= cfg_data;
				CFG_GPU_BASE:   gpu_base_q   <= cfg_data;
				CFG_STRIDE:     stride_q     <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(in_data[1:0]);
			idx_q <= in_data[IN_W-1:2];
		end
	end

	assign active   = (slot_count_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_q;
	assign idx_bad  = {1'b0, idx_q} >= active;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i] = ~used_q[i] & (CNT_W'(i) < active);
		end
	end

	// isolate lowest free bit, then encode
	assign low_bit = free_vec & (~free_vec + SLOTS'(1));
	assign found   = |free_vec;

	always_comb begin
		first_free = '0;
		for (int i = 0; i < SLOTS; i++) begin
			first_free = first_free | (low_bit[i] ? SLOT_W'(i) : '0);
		end
	end

	always_comb begin
		stat_d    = STAT_OK;
		slot_d    = idx_q;
		addr_en_d = 1'b0;
		set_en    = 1'b0;
		clr_en    = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				if (found) begin
					slot_d    = first_free;
					addr_en_d = 1'b1;
					set_en    = 1'b1;
				end else begin
					stat_d = STAT_FULL;
					slot_d = '0;
				end
			end
			OP_FREE: begin
				if (idx_bad) begin
					stat_d = STAT_RANGE;
				end else begin
					clr_en = 1'b1;
				end
			end
			OP_XLATE: begin
				if (idx_bad) begin
					stat_d = STAT_RANGE;
				end else begin
					addr_en_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.exec) begin
			if (set_en) begin
				used_q[slot_d] <= 1'b1;
			end
			if (clr_en) begin
				used_q[slot_d] <= 1'b0;
			end
		end
	end

	// search/update result and slot offset
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			stat_s1    <= stat_d;
			slot_s1    <= slot_d;
			addr_en_s1 <= addr_en_d;
			ofs_s1     <= OFS_W'(slot_d) * OFS_W'(stride_q);
		end
	end

	assign cpu_addr = addr_en_s1 ? cpu_base_q + ADDR_W'(ofs_s1) : '0;
	assign gpu_addr = addr_en_s1 ? gpu_base_q + ADDR_W'(ofs_s1) : '0;

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q <= {gpu_addr, cpu_addr, slot_s1, stat_s1};
		end
	end

	assign sts.out_free = ~out_valid_q | out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

endmodule

### src/bitmap_slot_allocator.sv
// top level: first-fit slot allocator over a used bitmap with address translation
// flow: a request beat is captured, then searched/updated into the result registers,
// then loaded into the output beat register once that register is free or being taken
// a request is taken only when idle or in the output load step, so one is in flight at a time
// reset: arst_n clears every used bit, sets slot_count 64, bases 0, stride 32
module bitmap_slot_allocator
	import bsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // opcode[1:0], slot_index[7:2]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // status[1:0], granted_slot[7:2],
	                                      // cpu_address[71:8], gpu_address[135:72]
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [ADDR_W-1:0]  cfg_data
);

	bsa_cmd_t cmd;
	bsa_sts_t sts;

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && cmd.exec)
		else $error("request taken while previous one in search");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!m_tvalid || m_tready))
		else $error("result beat overwritten before taken");

	a_no_addr_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != STAT_OK) |-> m_tdata[OUT_W-1:8] == '0)
		else $error("addresses present on error status");

	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == STAT_FULL) |-> m_tdata[7:2] == '0)
		else $error("pool full beat carries nonzero slot");

endmodule
